[hdl/brd_pkg.sv]
// ----------------------------------------------------------------------------
// brd_pkg
// shared constants, register codes, result tag type and width helpers
// ----------------------------------------------------------------------------
package brd_pkg;

    localparam int MAX_WIDTH_DEF = 4096;
    localparam int FRAC_BITS_DEF = 10;
    localparam int MAX_FLUSH_DEF = 4;

    localparam int PIXEL_W      = 8;
    localparam int OUT_IDX_W    = 12;
    localparam int FACTOR_REG_W = 16;
    localparam int WIDTH_REG_W  = 13;
    localparam int CFG_DATA_W   = 16;
    localparam int CFG_IDX_W    = 2;
    localparam int QUEUE_DEPTH  = 4;
    localparam int VALUE_MAX    = 255;

    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_FACTOR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_WIDTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_WIDTH = 2'd2;

    localparam logic [FACTOR_REG_W-1:0] SCALE_FACTOR_RESET = 16'd2048;
    localparam logic [WIDTH_REG_W-1:0]  SOURCE_WIDTH_RESET = 13'd4096;
    localparam logic [WIDTH_REG_W-1:0]  OUTPUT_WIDTH_RESET = 13'd2048;

    typedef logic [PIXEL_W-1:0] pixel_t;

    typedef struct packed {
        logic [OUT_IDX_W-1:0] out_index;
        logic                 row_done;
        logic                 run_last;
        logic                 dropped;
    } tag_t;

    // factor width, wide enough for the raised minimum factor
    function automatic int factor_w(int frac_bits);
        return (frac_bits >= FACTOR_REG_W) ? frac_bits + 1 : FACTOR_REG_W;
    endfunction

    // bits of the window length (at most integer part of factor plus two)
    function automatic int len_w(int frac_bits);
        return factor_w(frac_bits) - frac_bits + 1;
    endfunction

    function automatic int sum_w(int frac_bits);
        return len_w(frac_bits) + PIXEL_W;
    endfunction

endpackage

[hdl/brd_if.sv]
// ----------------------------------------------------------------------------
// brd_if
// valid/ready channels for source pixels and for averaged results
// ----------------------------------------------------------------------------
interface brd_pixel_if;
    logic            valid;
    logic            ready;
    brd_pkg::pixel_t pixel;

    modport source (output valid, output pixel, input ready);
    modport sink (input valid, input pixel, output ready);
endinterface

interface brd_result_if;
    logic                           valid;
    logic                           ready;
    logic [brd_pkg::PIXEL_W-1:0]    value;
    logic [brd_pkg::OUT_IDX_W-1:0]  out_index;
    logic                           row_done;
    logic                           run_last;
    logic                           dropped;

    modport source (output valid, output value, output out_index, output row_done,
                    output run_last, output dropped, input ready);
    modport sink (input valid, input value, input out_index, input row_done,
                  input run_last, input dropped, output ready);
endinterface

[hdl/box_filter_row_downscaler_top.sv]
// ----------------------------------------------------------------------------
// box_filter_row_downscaler_top
// throughput: one pixel beat per cycle while the job queue has room; the last
// pixel of a row holds the input until its flushed results are queued
// the divider takes a new job only after loading the last result for output
// results go from the job queue through the divider to the output register
// reset: asynchronous, clears counters, window, sums, queue and output;
// config registers return to their reset values
// ----------------------------------------------------------------------------
module box_filter_row_downscaler_top #(
    parameter int MAX_WIDTH = brd_pkg::MAX_WIDTH_DEF,
    parameter int FRAC_BITS = brd_pkg::FRAC_BITS_DEF,
    parameter int MAX_FLUSH = brd_pkg::MAX_FLUSH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [brd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [brd_pkg::CFG_DATA_W-1:0]  cfg_data,
    brd_pixel_if.sink                       pixel_in,
    brd_result_if.source                    result_out
);

    localparam int ENTRY_W = brd_pkg::sum_w(FRAC_BITS) + brd_pkg::len_w(FRAC_BITS)
                             + $bits(brd_pkg::tag_t);

    logic               push_valid, push_ready;
    logic [ENTRY_W-1:0] push_data;
    logic               pop_valid, pop_ready;
    logic [ENTRY_W-1:0] pop_data;

    brd_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .FRAC_BITS (FRAC_BITS),
        .MAX_FLUSH (MAX_FLUSH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .pix        (pixel_in),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    brd_queue #(
        .DATA_W (ENTRY_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    brd_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .res       (result_out)
    );

endmodule

[hdl/brd_front.sv]
// ----------------------------------------------------------------------------
// brd_front
// config registers, window tracking and running sums; queues one division
// job per completed window and steps through the end-of-row flush
// ----------------------------------------------------------------------------
module brd_front #(
    parameter int MAX_WIDTH = brd_pkg::MAX_WIDTH_DEF,
    parameter int FRAC_BITS = brd_pkg::FRAC_BITS_DEF,
    parameter int MAX_FLUSH = brd_pkg::MAX_FLUSH_DEF,
    localparam int ENTRY_W  = brd_pkg::sum_w(FRAC_BITS) + brd_pkg::len_w(FRAC_BITS)
                              + $bits(brd_pkg::tag_t)
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [brd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [brd_pkg::CFG_DATA_W-1:0]  cfg_data,
    brd_pixel_if.sink                       pix,
    output logic                            push_valid,
    input  logic                            push_ready,
    output logic [ENTRY_W-1:0]              push_data
);

    localparam int FACT_W = brd_pkg::factor_w(FRAC_BITS);
    localparam int LEN_W  = brd_pkg::len_w(FRAC_BITS);
    localparam int SUM_W  = brd_pkg::sum_w(FRAC_BITS);
    localparam int CNT_W  = $clog2(MAX_WIDTH + 1);
    localparam int POS_W  = FACT_W + $clog2(MAX_WIDTH + 2);
    localparam int IDX_W  = POS_W - FRAC_BITS + 1;
    localparam int FL_W   = $clog2(MAX_FLUSH + 1);
    localparam logic [FACT_W-1:0] F_MIN = FACT_W'((64'd1 << FRAC_BITS) + 64'd1);
    localparam logic [POS_W:0]    ROUND = (POS_W + 1)'((64'd1 << FRAC_BITS) - 64'd1);

    logic [brd_pkg::FACTOR_REG_W-1:0] scale_factor_reg;
    logic [brd_pkg::WIDTH_REG_W-1:0]  source_width_reg;
    logic [brd_pkg::WIDTH_REG_W-1:0]  output_width_reg;

    logic [CNT_W-1:0] sc_reg, sc_next;
    logic [CNT_W-1:0] oc_reg, oc_next;
    logic [POS_W-1:0] start_reg, start_next;
    logic [POS_W-1:0] end_reg, end_next;
    logic [SUM_W-1:0] cur_reg, cur_next;
    logic [SUM_W-1:0] nxt_reg, nxt_next;
    logic [FL_W-1:0]  flush_left_reg, flush_left_next;
    logic             drop_reg, drop_next;

    logic [FACT_W-1:0] f_eff;
    logic [CNT_W-1:0]  sw, ow;
    logic              flushing, row_start, in_fire, push, flush_final;
    logic [POS_W-1:0]  st, en;
    logic [SUM_W-1:0]  cs, ns, cs_add, ns_add;
    logic [CNT_W-1:0]  oc, owed;
    logic [CNT_W:0]    oc1;
    logic [POS_W:0]    hi_sum;
    logic [IDX_W-1:0]  lo, hi, nlo, s_x, s_next, len_diff;
    logic              in_cur, in_nxt, active, last, emit, drop;
    logic [LEN_W-1:0]  len;
    logic [FL_W-1:0]   cnt;
    brd_pkg::tag_t     tag;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_factor_reg <= brd_pkg::SCALE_FACTOR_RESET;
            source_width_reg <= brd_pkg::SOURCE_WIDTH_RESET;
            output_width_reg <= brd_pkg::OUTPUT_WIDTH_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                brd_pkg::CFG_SCALE_FACTOR: scale_factor_reg <= cfg_data;
                brd_pkg::CFG_SOURCE_WIDTH:
                    source_width_reg <= cfg_data[brd_pkg::WIDTH_REG_W-1:0];
                brd_pkg::CFG_OUTPUT_WIDTH:
                    output_width_reg <= cfg_data[brd_pkg::WIDTH_REG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        f_eff = (FACT_W'(scale_factor_reg) < F_MIN) ? F_MIN : FACT_W'(scale_factor_reg);

        if (source_width_reg == '0)
            sw = CNT_W'(1);
        else if (32'(source_width_reg) > 32'(MAX_WIDTH))
            sw = CNT_W'(MAX_WIDTH);
        else
            sw = CNT_W'(source_width_reg);

        if (output_width_reg == '0)
            ow = CNT_W'(1);
        else if (32'(output_width_reg) > 32'(MAX_WIDTH))
            ow = CNT_W'(MAX_WIDTH);
        else
            ow = CNT_W'(output_width_reg);
    end

    assign flushing  = (flush_left_reg != '0);
    assign row_start = (sc_reg == '0) && !flushing;
    assign pix.ready = !flushing && push_ready;
    assign in_fire   = pix.valid && pix.ready;

    // window as seen by this beat, fresh at row start
    assign st = row_start ? '0 : start_reg;
    assign en = row_start ? POS_W'(f_eff) : end_reg;
    assign cs = row_start ? '0 : cur_reg;
    assign ns = row_start ? '0 : nxt_reg;
    assign oc = row_start ? '0 : oc_reg;

    assign hi_sum = {1'b0, en} + ROUND;
    assign lo     = IDX_W'(st >> FRAC_BITS);
    assign hi     = IDX_W'(hi_sum >> FRAC_BITS);
    assign nlo    = IDX_W'(en >> FRAC_BITS);
    assign s_x    = IDX_W'(sc_reg);
    assign s_next = s_x + IDX_W'(1);

    assign in_cur = in_fire && (s_x >= lo) && (s_x < hi);
    assign in_nxt = in_fire && (s_x >= nlo);
    assign cs_add = cs + (in_cur ? SUM_W'(pix.pixel) : '0);
    assign ns_add = ns + (in_nxt ? SUM_W'(pix.pixel) : '0);

    assign oc1    = {1'b0, oc} + (CNT_W + 1)'(1);
    assign active = (oc < ow);
    assign last   = (({1'b0, sc_reg} + (CNT_W + 1)'(1)) >= {1'b0, sw});
    assign emit   = active && !last && (s_next >= hi);

    assign len_diff = hi - lo;
    assign len      = (hi > lo) ? LEN_W'(len_diff) : LEN_W'(1);

    assign owed = ow - oc;
    assign drop = (32'(owed) > 32'(MAX_FLUSH));
    assign cnt  = drop ? FL_W'(MAX_FLUSH) : FL_W'(owed);

    assign flush_final   = flushing && (flush_left_reg == FL_W'(1));
    assign tag.out_index = brd_pkg::OUT_IDX_W'(oc);
    assign tag.row_done  = (oc1 == {1'b0, ow}) || flush_final;
    assign tag.run_last  = !flushing || flush_final;
    assign tag.dropped   = flushing && drop_reg;

    assign push_valid = (in_fire && emit) || flushing;
    assign push       = push_valid && push_ready;
    assign push_data  = {cs_add, len, tag};

    always_comb
    begin
        sc_next         = sc_reg;
        oc_next         = oc_reg;
        start_next      = start_reg;
        end_next        = end_reg;
        cur_next        = cur_reg;
        nxt_next        = nxt_reg;
        flush_left_next = flush_left_reg;
        drop_next       = drop_reg;

        if (in_fire)
        begin
            oc_next    = oc;
            start_next = st;
            end_next   = en;
            cur_next   = cs_add;
            nxt_next   = ns_add;
            sc_next    = last ? '0 : sc_reg + CNT_W'(1);
            if (last && active)
            begin
                flush_left_next = cnt;
                drop_next       = drop;
            end
        end

        if (flushing && push_ready)
            flush_left_next = flush_left_reg - FL_W'(1);

        // window closed: move on to the next one
        if (push)
        begin
            cur_next   = ns_add;
            nxt_next   = '0;
            start_next = en;
            end_next   = en + POS_W'(f_eff);
            oc_next    = CNT_W'(oc1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sc_reg         <= '0;
            oc_reg         <= '0;
            start_reg      <= '0;
            end_reg        <= '0;
            cur_reg        <= '0;
            nxt_reg        <= '0;
            flush_left_reg <= '0;
            drop_reg       <= 1'b0;
        end
        else
        begin
            sc_reg         <= sc_next;
            oc_reg         <= oc_next;
            start_reg      <= start_next;
            end_reg        <= end_next;
            cur_reg        <= cur_next;
            nxt_reg        <= nxt_next;
            flush_left_reg <= flush_left_next;
            drop_reg       <= drop_next;
        end
    end

endmodule

[hdl/brd_queue.sv]
// ----------------------------------------------------------------------------
// brd_queue
// short job queue between window tracking and the divider
// ----------------------------------------------------------------------------
module brd_queue #(
    parameter int DATA_W = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  logic [DATA_W-1:0] push_data,
    output logic              pop_valid,
    input  logic              pop_ready,
    output logic [DATA_W-1:0] pop_data
);

    localparam int DEPTH = brd_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              push, pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            if (push && !pop)
                count_reg <= count_reg + CNT_W'(1);
            else if (pop && !push)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

endmodule

[hdl/brd_back.sv]
// ----------------------------------------------------------------------------
// brd_back
// bit-serial rounding divider and result output register
// ----------------------------------------------------------------------------
module brd_back #(
    parameter int FRAC_BITS = brd_pkg::FRAC_BITS_DEF,
    localparam int ENTRY_W  = brd_pkg::sum_w(FRAC_BITS) + brd_pkg::len_w(FRAC_BITS)
                              + $bits(brd_pkg::tag_t)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               pop_valid,
    output logic               pop_ready,
    input  logic [ENTRY_W-1:0] pop_data,
    brd_result_if.source       res
);

    localparam int LEN_W  = brd_pkg::len_w(FRAC_BITS);
    localparam int SUM_W  = brd_pkg::sum_w(FRAC_BITS);
    localparam int TAG_W  = $bits(brd_pkg::tag_t);
    localparam int NUM_W  = SUM_W + 2;
    localparam int DEN_W  = LEN_W + 1;
    localparam int STEP_W = $clog2(NUM_W);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_HOLD = 2'd2;

    logic [1:0]        state_reg;
    logic [STEP_W-1:0] step_reg;
    logic              out_valid_reg;
    logic [NUM_W-1:0]  quo_reg;
    logic [DEN_W-1:0]  rem_reg, den_reg;
    brd_pkg::tag_t     tag_reg;
    logic [brd_pkg::PIXEL_W-1:0] value_reg;
    brd_pkg::tag_t     out_tag_reg;

    logic [SUM_W-1:0]  e_sum;
    logic [LEN_W-1:0]  e_len;
    logic [DEN_W:0]    trial, diff;
    logic              ge, take, load;

    assign e_sum = pop_data[ENTRY_W-1 -: SUM_W];
    assign e_len = pop_data[TAG_W +: LEN_W];

    assign pop_ready = (state_reg == ST_IDLE);
    assign take      = pop_valid && pop_ready;
    assign load      = (state_reg == ST_HOLD) && (!out_valid_reg || res.ready);

    // restoring step, one quotient bit per cycle
    assign trial = {rem_reg, quo_reg[NUM_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = (trial >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (take)
                    begin
                        state_reg <= ST_DIV;
                        step_reg  <= '0;
                    end
                end
                ST_DIV:
                begin
                    step_reg <= step_reg + STEP_W'(1);
                    if (step_reg == STEP_W'(NUM_W - 1))
                        state_reg <= ST_HOLD;
                end
                ST_HOLD:
                begin
                    if (load)
                        state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase

            if (load)
                out_valid_reg <= 1'b1;
            else if (res.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            quo_reg <= NUM_W'({e_sum, 1'b0}) + NUM_W'(e_len);
            rem_reg <= '0;
            den_reg <= {e_len, 1'b0};
            tag_reg <= brd_pkg::tag_t'(pop_data[TAG_W-1:0]);
        end
        else if (state_reg == ST_DIV)
        begin
            rem_reg <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            quo_reg <= {quo_reg[NUM_W-2:0], ge};
        end

        if (load)
        begin
            value_reg   <= (quo_reg > NUM_W'(brd_pkg::VALUE_MAX)) ?
                           brd_pkg::PIXEL_W'(brd_pkg::VALUE_MAX) :
                           quo_reg[brd_pkg::PIXEL_W-1:0];
            out_tag_reg <= tag_reg;
        end
    end

    assign res.valid     = out_valid_reg;
    assign res.value     = value_reg;
    assign res.out_index = out_tag_reg.out_index;
    assign res.row_done  = out_tag_reg.row_done;
    assign res.run_last  = out_tag_reg.run_last;
    assign res.dropped   = out_tag_reg.dropped;

endmodule

[hdl/brd_checker.sv]
// ----------------------------------------------------------------------------
// brd_checker
// port-level checks on result ordering and flush marking
// ----------------------------------------------------------------------------
module brd_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           cfg_we,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic [brd_pkg::PIXEL_W-1:0]    out_value,
    input logic [brd_pkg::OUT_IDX_W-1:0]  out_index,
    input logic                           row_done,
    input logic                           run_last,
    input logic                           dropped
);

    logic                          out_fire;
    logic                          idx_known_reg;
    logic [brd_pkg::OUT_IDX_W-1:0] expect_reg;
    logic                          drop_open_reg;

    assign out_fire = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_known_reg <= 1'b1;
            expect_reg    <= '0;
            drop_open_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            idx_known_reg <= 1'b0;
            drop_open_reg <= 1'b0;
        end
        else if (out_fire)
        begin
            idx_known_reg <= 1'b1;
            expect_reg    <= row_done ? '0 : out_index + brd_pkg::OUT_IDX_W'(1);
            drop_open_reg <= dropped && !run_last;
        end
    end

    // stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_value) &&
        $stable(out_index) && $stable(row_done) && $stable(run_last) && $stable(dropped))
        else $error("result beat changed while stalled");

    // outputs of a row come in index order from zero
    a_index_seq: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire && idx_known_reg |-> out_index == expect_reg)
        else $error("result index out of sequence");

    // a cut-off flush marks all of its results
    a_drop_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire && drop_open_reg |-> dropped)
        else $error("dropped flag missing inside a cut-off flush");

    // a cut-off flush always closes the row
    a_flush_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire && dropped && run_last |-> row_done)
        else $error("cut-off flush ended without row_done");

endmodule

bind box_filter_row_downscaler_top brd_checker u_brd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .out_valid (result_out.valid),
    .out_ready (result_out.ready),
    .out_value (result_out.value),
    .out_index (result_out.out_index),
    .row_done  (result_out.row_done),
    .run_last  (result_out.run_last),
    .dropped   (result_out.dropped)
);

[test/box_filter_row_downscaler_top_tb.sv]
// ----------------------------------------------------------------------------
// box_filter_row_downscaler_top_tb
// Streams rows of source pixels into the area-average row downscaler and
// checks every averaged result beat against fixed values in the directed
// table or an in-bench predictor of the window sums, the rounded division
// and the end-of-row flush. The short table comes first, followed by random
// register settings and pixel streams, with random idle cycles on both
// channels and one long receiver hold-off that backs the block up to its input.
// ----------------------------------------------------------------------------
module box_filter_row_downscaler_top_tb;

    localparam int          FRAC         = brd_pkg::FRAC_BITS_DEF;
    localparam int unsigned UNIT_POS     = 1 << FRAC;
    localparam int unsigned MIN_FACTOR   = UNIT_POS + 1;
    localparam int          PIXEL_TARGET = 410;
    localparam int          SETTLE_CYCLES = 64;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          PRESSURE_PHASE = 3;
    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          DIR_ROWS     = 37;

    typedef enum logic {ROW_CFG, ROW_PIX} row_kind_t;

    typedef struct packed {
        row_kind_t                       kind;
        logic [brd_pkg::CFG_IDX_W-1:0]   reg_idx;
        logic [brd_pkg::CFG_DATA_W-1:0]  reg_data;
        brd_pkg::pixel_t                 pixel;
        logic                            known;
        logic                            has_res;
        logic [brd_pkg::PIXEL_W-1:0]     value;
        logic [brd_pkg::OUT_IDX_W-1:0]   out_index;
        logic                            row_done;
    } dir_row_t;

    typedef struct packed {
        logic [brd_pkg::PIXEL_W-1:0]     value;
        logic [brd_pkg::OUT_IDX_W-1:0]   out_index;
        logic                            row_done;
        logic                            run_last;
        logic                            dropped;
    } box_result_t;

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_we;
    logic [brd_pkg::CFG_IDX_W-1:0]   cfg_index;
    logic [brd_pkg::CFG_DATA_W-1:0]  cfg_data;

    brd_pixel_if  pix_bus ();
    brd_result_if res_bus ();

    box_filter_row_downscaler_top i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .pixel_in   (pix_bus),
        .result_out (res_bus)
    );

    // predictor copy of the registers and the row state
    logic [brd_pkg::FACTOR_REG_W-1:0] factor_reg;
    logic [brd_pkg::WIDTH_REG_W-1:0]  src_width_reg;
    logic [brd_pkg::WIDTH_REG_W-1:0]  out_width_reg;
    int unsigned             row_pos;
    int unsigned             out_pos;
    int unsigned             win_lo_pos;
    int unsigned             win_hi_pos;
    int unsigned             sum_cur;
    int unsigned             sum_next;

    box_result_t  step_results[$];
    box_result_t  avg_due[$];
    dir_row_t     directed_rows [DIR_ROWS];

    int  mismatches;
    int  results_seen;
    int  drops_seen;
    int  pixels_fed;
    int  cycle_count;
    bit  gaps_on;
    bit  res_gaps;
    bit  hold_req;
    bit  fed_since_settle;

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int unsigned clamp_width(logic [brd_pkg::WIDTH_REG_W-1:0] w);
        if (w == 0)
        begin
            return 1;
        end
        if (w > brd_pkg::MAX_WIDTH_DEF)
        begin
            return brd_pkg::MAX_WIDTH_DEF;
        end
        return 32'(w);
    endfunction

    // rounded average of the current window, then step to the next one
    function automatic box_result_t close_window(int unsigned ow, int unsigned f);
        int unsigned  lo;
        int unsigned  hi;
        int unsigned  len;
        int unsigned  avg;
        box_result_t  r;
        lo = win_lo_pos >> FRAC;
        hi = (win_hi_pos + UNIT_POS - 1) >> FRAC;
        len = (hi > lo) ? hi - lo : 1;
        avg = (2 * sum_cur + len) / (2 * len);
        if (avg > brd_pkg::VALUE_MAX)
        begin
            avg = brd_pkg::VALUE_MAX;
        end
        r.value = avg[brd_pkg::PIXEL_W-1:0];
        r.out_index = out_pos[brd_pkg::OUT_IDX_W-1:0];
        r.row_done = (out_pos + 1 == ow);
        r.run_last = 1'b0;
        r.dropped = 1'b0;
        sum_cur = sum_next;
        sum_next = 0;
        win_lo_pos = win_hi_pos;
        win_hi_pos = win_hi_pos + f;
        out_pos++;
        return r;
    endfunction

    function automatic void downscale_pixel(brd_pkg::pixel_t p);
        int unsigned  sw;
        int unsigned  ow;
        int unsigned  f;
        int unsigned  s;
        int unsigned  lo;
        int unsigned  hi;
        int unsigned  nlo;
        int unsigned  owed;
        int unsigned  cnt;
        bit           last;
        bit           drop;
        box_result_t  r;
        sw = clamp_width(src_width_reg);
        ow = clamp_width(out_width_reg);
        f = (32'(factor_reg) < MIN_FACTOR) ? MIN_FACTOR : 32'(factor_reg);
        step_results.delete();
        if (row_pos == 0)
        begin
            win_lo_pos = 0;
            win_hi_pos = f;
            sum_cur = 0;
            sum_next = 0;
            out_pos = 0;
        end
        s = row_pos;
        last = (s + 1 >= sw);
        if (out_pos < ow)
        begin
            lo = win_lo_pos >> FRAC;
            hi = (win_hi_pos + UNIT_POS - 1) >> FRAC;
            nlo = win_hi_pos >> FRAC;
            if (s >= lo && s < hi)
            begin
                sum_cur += 32'(p);
            end
            if (s >= nlo)
            begin
                sum_next += 32'(p);
            end
            if (!last)
            begin
                if (s + 1 >= hi)
                begin
                    r = close_window(ow, f);
                    r.run_last = 1'b1;
                    step_results.push_back(r);
                end
            end
            else
            begin
                owed = ow - out_pos;
                drop = (owed > brd_pkg::MAX_FLUSH_DEF);
                cnt = drop ? brd_pkg::MAX_FLUSH_DEF : owed;
                for (int i = 0; i < cnt; i++)
                begin
                    r = close_window(ow, f);
                    r.dropped = drop;
                    if (i == cnt - 1)
                    begin
                        r.row_done = 1'b1;
                        r.run_last = 1'b1;
                    end
                    step_results.push_back(r);
                end
            end
        end
        row_pos = last ? 0 : s + 1;
    endfunction

    function automatic dir_row_t cfg_row(logic [brd_pkg::CFG_IDX_W-1:0] idx,
                                         logic [brd_pkg::CFG_DATA_W-1:0] data);
        dir_row_t row;
        row = '0;
        row.kind = ROW_CFG;
        row.reg_idx = idx;
        row.reg_data = data;
        return row;
    endfunction

    function automatic dir_row_t pix_row(brd_pkg::pixel_t p);
        dir_row_t row;
        row = '0;
        row.kind = ROW_PIX;
        row.pixel = p;
        return row;
    endfunction

    function automatic dir_row_t fix_row(brd_pkg::pixel_t p, logic has_res,
                                         logic [brd_pkg::PIXEL_W-1:0] value,
                                         logic [brd_pkg::OUT_IDX_W-1:0] idx, logic done);
        dir_row_t row;
        row = pix_row(p);
        row.known = 1'b1;
        row.has_res = has_res;
        row.value = value;
        row.out_index = idx;
        row.row_done = done;
        return row;
    endfunction

    function automatic logic [brd_pkg::CFG_DATA_W-1:0] pick_width();
        logic [brd_pkg::CFG_DATA_W-1:0] w;
        case ($urandom_range(0, 5))
            0: w = 16'd0;
            1: w = 16'd4096;
            2: w = 16'd8191;
            default: w = 16'($urandom_range(1, 40));
        endcase
        // upper data bits lie outside the register
        return w | (16'($urandom_range(0, 7)) << brd_pkg::WIDTH_REG_W);
    endfunction

    task automatic write_reg(input logic [brd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [brd_pkg::CFG_DATA_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            brd_pkg::CFG_SCALE_FACTOR: factor_reg = data;
            brd_pkg::CFG_SOURCE_WIDTH: src_width_reg = data[brd_pkg::WIDTH_REG_W-1:0];
            brd_pkg::CFG_OUTPUT_WIDTH: out_width_reg = data[brd_pkg::WIDTH_REG_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic feed_pixel(input brd_pkg::pixel_t p, input bit from_model);
        int gap;
        gap = gaps_on ? $urandom_range(0, 3) : 0;
        if (gap > 0)
        begin
            pix_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix_bus.valid <= 1'b1;
        pix_bus.pixel <= p;
        @(posedge clk);
        while (pix_bus.ready !== 1'b1) @(posedge clk);
        downscale_pixel(p);
        if (from_model)
        begin
            foreach (step_results[i])
            begin
                avg_due.push_back(step_results[i]);
            end
        end
        pixels_fed++;
        fed_since_settle = 1'b1;
    endtask

    task automatic settle_block();
        pix_bus.valid <= 1'b0;
        while (avg_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        fed_since_settle = 1'b0;
    endtask

    task automatic compare_field(input string name, input logic [15:0] want,
                                 input logic [15:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    // result beat checker
    always @(posedge clk)
    begin
        box_result_t want;
        if (rst_n === 1'b1 && res_bus.valid === 1'b1 && res_bus.ready === 1'b1)
        begin
            results_seen++;
            if (res_bus.dropped === 1'b1)
            begin
                drops_seen++;
            end
            if (avg_due.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected beat, expected none actual index %0d value %0d",
                         $time, res_bus.out_index, res_bus.value);
            end
            else
            begin
                want = avg_due.pop_front();
                compare_field("value", 16'(want.value), 16'(res_bus.value));
                compare_field("out_index", 16'(want.out_index), 16'(res_bus.out_index));
                compare_field("row_done", 16'(want.row_done), 16'(res_bus.row_done));
                compare_field("run_last", 16'(want.run_last), 16'(res_bus.run_last));
                compare_field("dropped", 16'(want.dropped), 16'(res_bus.dropped));
            end
        end
    end

    // result receiver
    initial
    begin
        int  gap;
        int  taken;
        bit  hold_done;
        res_bus.ready <= 1'b0;
        taken = 0;
        hold_done = 1'b0;
        res_gaps = 1'b1;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                res_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                gap = res_gaps ? $urandom_range(0, 3) : 0;
                if (gap > 0)
                begin
                    res_bus.ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            res_bus.ready <= 1'b1;
            @(posedge clk);
            while (res_bus.valid !== 1'b1) @(posedge clk);
            taken++;
            if (taken % 40 == 0)
            begin
                res_gaps = ($urandom_range(0, 1) != 0);
            end
        end
    end

    // run limit
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                 avg_due.size());
        $display("Regression FAIL");
        $finish;
    end

    // stimulus
    initial
    begin
        dir_row_t     row;
        box_result_t  typed;
        int           phase;
        int           n;
        int           sf;
        int           sw;
        int           ow;
        int           rest;
        int           pick;
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= brd_pkg::CFG_SCALE_FACTOR;
        cfg_data <= '0;
        pix_bus.valid <= 1'b0;
        pix_bus.pixel <= '0;
        factor_reg = brd_pkg::SCALE_FACTOR_RESET;
        src_width_reg = brd_pkg::SOURCE_WIDTH_RESET;
        out_width_reg = brd_pkg::OUTPUT_WIDTH_RESET;
        row_pos = 0;
        out_pos = 0;
        win_lo_pos = 0;
        win_hi_pos = 0;
        sum_cur = 0;
        sum_next = 0;
        mismatches = 0;
        results_seen = 0;
        drops_seen = 0;
        pixels_fed = 0;
        hold_req = 1'b0;
        fed_since_settle = 1'b0;
        gaps_on = 1'b1;

        directed_rows = '{
            // reset settings, then shrink the width mid-row to force a cut flush
            pix_row(8'd10),
            fix_row(8'd20, 1'b1, 8'd15, 12'd0, 1'b0),
            cfg_row(brd_pkg::CFG_SOURCE_WIDTH, 16'd3),
            pix_row(8'd200),
            // factor two, four pixels into two outputs: full scale then zero
            cfg_row(brd_pkg::CFG_SCALE_FACTOR, 16'd2048),
            cfg_row(brd_pkg::CFG_SOURCE_WIDTH, 16'd4),
            cfg_row(brd_pkg::CFG_OUTPUT_WIDTH, 16'd2),
            fix_row(8'd255, 1'b0, 8'd0, 12'd0, 1'b0),
            fix_row(8'd255, 1'b1, 8'd255, 12'd0, 1'b0),
            fix_row(8'd255, 1'b0, 8'd0, 12'd0, 1'b0),
            fix_row(8'd255, 1'b1, 8'd255, 12'd1, 1'b1),
            fix_row(8'd0, 1'b0, 8'd0, 12'd0, 1'b0),
            fix_row(8'd0, 1'b1, 8'd0, 12'd0, 1'b0),
            fix_row(8'd0, 1'b0, 8'd0, 12'd0, 1'b0),
            fix_row(8'd0, 1'b1, 8'd0, 12'd1, 1'b1),
            // factor at or below one is raised
            cfg_row(brd_pkg::CFG_SCALE_FACTOR, 16'd0),
            cfg_row(brd_pkg::CFG_SOURCE_WIDTH, 16'd8),
            cfg_row(brd_pkg::CFG_OUTPUT_WIDTH, 16'd8),
            pix_row(8'd0),
            pix_row(8'd255),
            pix_row(8'd1),
            pix_row(8'd128),
            pix_row(8'd254),
            pix_row(8'd127),
            // largest factor, zero and oversized widths
            cfg_row(brd_pkg::CFG_SCALE_FACTOR, 16'd65535),
            cfg_row(brd_pkg::CFG_SOURCE_WIDTH, 16'd0),
            cfg_row(brd_pkg::CFG_OUTPUT_WIDTH, 16'd8191),
            pix_row(8'd255),
            pix_row(8'd0),
            // all outputs done early, rest of row silent
            cfg_row(brd_pkg::CFG_SCALE_FACTOR, 16'd2048),
            cfg_row(brd_pkg::CFG_SOURCE_WIDTH, 16'd5),
            cfg_row(brd_pkg::CFG_OUTPUT_WIDTH, 16'd1),
            fix_row(8'd100, 1'b0, 8'd0, 12'd0, 1'b0),
            fix_row(8'd50, 1'b1, 8'd75, 12'd0, 1'b1),
            fix_row(8'd9, 1'b0, 8'd0, 12'd0, 1'b0),
            fix_row(8'd200, 1'b0, 8'd0, 12'd0, 1'b0),
            fix_row(8'd33, 1'b0, 8'd0, 12'd0, 1'b0)
        };

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < DIR_ROWS; r++)
        begin
            row = directed_rows[r];
            if (row.kind == ROW_CFG)
            begin
                if (fed_since_settle)
                begin
                    settle_block();
                end
                write_reg(row.reg_idx, row.reg_data);
            end
            else
            begin
                feed_pixel(row.pixel, !row.known);
                if (row.known && row.has_res)
                begin
                    typed.value = row.value;
                    typed.out_index = row.out_index;
                    typed.row_done = row.row_done;
                    typed.run_last = 1'b1;
                    typed.dropped = 1'b0;
                    avg_due.push_back(typed);
                end
            end
        end

        phase = 0;
        while (pixels_fed < PIXEL_TARGET)
        begin
            settle_block();
            phase++;
            gaps_on = ($urandom_range(0, 3) != 0);
            if (phase == PRESSURE_PHASE)
            begin
                write_reg(brd_pkg::CFG_SCALE_FACTOR, brd_pkg::SCALE_FACTOR_RESET);
                write_reg(brd_pkg::CFG_SOURCE_WIDTH, 16'(brd_pkg::SOURCE_WIDTH_RESET));
                write_reg(brd_pkg::CFG_OUTPUT_WIDTH, 16'(brd_pkg::OUTPUT_WIDTH_RESET));
                n = 80;
                gaps_on = 1'b0;
                hold_req = 1'b1;
            end
            else if ($urandom_range(0, 9) < 7)
            begin
                // whole rows with an output width within one of the matching width
                pick = $urandom_range(0, 9);
                sf = (pick == 0) ? 65535 : (pick == 1) ? 1025 : $urandom_range(1025, 6144);
                sw = $urandom_range(1, 24);
                ow = (sw * int'(UNIT_POS) + sf - 1) / sf;
                ow = ow + int'($urandom_range(0, 2)) - 1;
                if (ow < 1)
                begin
                    ow = 1;
                end
                write_reg(brd_pkg::CFG_SCALE_FACTOR, 16'(sf));
                write_reg(brd_pkg::CFG_SOURCE_WIDTH, 16'(sw));
                write_reg(brd_pkg::CFG_OUTPUT_WIDTH, 16'(ow));
                rest = (row_pos + 1 >= sw) ? 1 : sw - int'(row_pos);
                n = rest + sw * int'($urandom_range(0, 2));
            end
            else
            begin
                // partial register changes, often mid-row
                if ($urandom_range(0, 1))
                begin
                    case ($urandom_range(0, 4))
                        0: write_reg(brd_pkg::CFG_SCALE_FACTOR, 16'd0);
                        1: write_reg(brd_pkg::CFG_SCALE_FACTOR, 16'd1024);
                        2: write_reg(brd_pkg::CFG_SCALE_FACTOR, 16'd1025);
                        3: write_reg(brd_pkg::CFG_SCALE_FACTOR, 16'd65535);
                        default: write_reg(brd_pkg::CFG_SCALE_FACTOR,
                                           16'($urandom_range(0, 65535)));
                    endcase
                end
                if ($urandom_range(0, 1))
                begin
                    write_reg(brd_pkg::CFG_SOURCE_WIDTH, pick_width());
                end
                if ($urandom_range(0, 1))
                begin
                    write_reg(brd_pkg::CFG_OUTPUT_WIDTH, pick_width());
                end
                n = $urandom_range(1, 20);
            end
            for (int k = 0; k < n; k++)
            begin
                feed_pixel(brd_pkg::pixel_t'($urandom_range(0, 255)), 1'b1);
            end
        end

        settle_block();
        $display("covered %0d pixels and %0d result beats (%0d flagged dropped)",
                 pixels_fed, results_seen, drops_seen);
        $display("over %0d random register phases plus the directed table, %0d mismatches",
                 phase, mismatches);
        if (mismatches == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

[filelist.f]
hdl/brd_pkg.sv
hdl/brd_if.sv
hdl/brd_front.sv
hdl/brd_queue.sv
hdl/brd_back.sv
hdl/box_filter_row_downscaler_top.sv
hdl/brd_checker.sv
test/box_filter_row_downscaler_top_tb.sv
